// ===== src/dtts_pkg.sv =====
// shared types and constants for the dual timer / tod / serial adapter
// no dependencies
package dtts_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_TOD   = 3'd3,
        CMD_SP    = 3'd4,
        CMD_CNT   = 3'd5,
        CMD_FLAG  = 3'd6,
        CMD_NONE  = 3'd7
    } t_cmd;

    localparam logic [3:0] REG_PRA  = 4'h0;
    localparam logic [3:0] REG_PRB  = 4'h1;
    localparam logic [3:0] REG_DDRA = 4'h2;
    localparam logic [3:0] REG_DDRB = 4'h3;
    localparam logic [3:0] REG_TALO = 4'h4;
    localparam logic [3:0] REG_TAHI = 4'h5;
    localparam logic [3:0] REG_TBLO = 4'h6;
    localparam logic [3:0] REG_TBHI = 4'h7;
    localparam logic [3:0] REG_TOD0 = 4'h8;
    localparam logic [3:0] REG_TOD1 = 4'h9;
    localparam logic [3:0] REG_TOD2 = 4'hA;
    localparam logic [3:0] REG_TOD3 = 4'hB;
    localparam logic [3:0] REG_SDR  = 4'hC;
    localparam logic [3:0] REG_ICR  = 4'hD;
    localparam logic [3:0] REG_CRA  = 4'hE;
    localparam logic [3:0] REG_CRB  = 4'hF;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture item, do single-step work
        logic clk_en;  // one system clock step
        logic finish;  // latch result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
    } t_sts;

endpackage

// ===== src/dtts_datapath.sv =====
// register file, timers, tod and serial port of the adapter
// depends on dtts_pkg
module dtts_datapath #(
    parameter int MAX_CLOCKS_PER_TICK = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtts_pkg::t_ctl   i_ctl,
    output dtts_pkg::t_sts   o_sts,
    output logic             o_last,
    output logic             o_zero,
    input  logic [2:0]       i_cmd,
    input  logic [3:0]       i_reg_addr,
    input  logic [7:0]       i_write_data,
    input  logic [6:0]       i_clock_count,
    input  logic             i_pin_level,
    output logic [7:0]       o_read_data,
    output logic             o_irq_out,
    output logic             o_sp_drive,
    output logic             o_cnt_drive,
    output logic             o_timer_a_wrapped,
    output logic             o_timer_b_wrapped
);
    localparam int CW = $clog2(MAX_CLOCKS_PER_TICK + 1) > 7 ?
                        $clog2(MAX_CLOCKS_PER_TICK + 1) : 7;
    localparam logic [CW-1:0] MAXC = CW'(MAX_CLOCKS_PER_TICK);

    logic [7:0]  r_pra, r_prb, r_ddra, r_ddrb, r_flags, r_cra, r_crb, r_sdr, r_sr;
    logic [6:0]  r_mask;
    logic [15:0] r_rla, r_cnta, r_rlb, r_cntb;
    logic        r_runa, r_runb, r_wa, r_wb;
    logic [7:0]  r_tod [4];
    logic [7:0]  r_alm [4];
    logic [7:0]  r_snap [4];
    logic [2:0]  r_pre;
    logic        r_halt, r_held, r_spend, r_sact;
    logic [3:0]  r_bits;
    logic        r_spin, r_cntin, r_flagin, r_spout, r_cntout;
    logic [CW-1:0] r_left;
    logic [7:0]  r_rd;

    logic [7:0]  n_pra, n_prb, n_ddra, n_ddrb, n_flags, n_cra, n_crb, n_sdr, n_sr;
    logic [6:0]  n_mask;
    logic [15:0] n_rla, n_cnta, n_rlb, n_cntb;
    logic        n_runa, n_runb, n_wa, n_wb;
    logic [7:0]  n_tod [4];
    logic [7:0]  n_alm [4];
    logic [7:0]  n_snap [4];
    logic [2:0]  n_pre;
    logic        n_halt, n_held, n_spend, n_sact;
    logic [3:0]  n_bits;
    logic        n_spin, n_cntin, n_flagin, n_spout, n_cntout;
    logic [CW-1:0] n_left;
    logic [7:0]  n_rd;

    // bcd digit step with wrap flag
    function automatic logic [8:0] bcd_step(input logic [7:0] v, input logic [7:0] lim);
        logic [4:0] lo;
        logic [7:0] hi;
        logic [7:0] r;
        lo = {1'b0, v[3:0]} + 5'd1;
        hi = {v[7:4], 4'h0};
        if (lo == 5'd10) begin
            lo = 5'd0;
            hi = hi + 8'h10;
        end
        r = hi | {3'b0, lo};
        if (r > lim) bcd_step = {1'b1, 8'h00};
        else bcd_step = {1'b0, r};
    endfunction

    always_comb begin
        logic ua, tb, ub, rising, chg, alarm_chk, c0, c1, c2;
        logic [8:0] s0, s1, s2;
        logic [7:0] v, hr, pm;
        logic [CW-1:0] cc;
        n_pra = r_pra; n_prb = r_prb; n_ddra = r_ddra; n_ddrb = r_ddrb;
        n_flags = r_flags; n_cra = r_cra; n_crb = r_crb; n_sdr = r_sdr; n_sr = r_sr;
        n_mask = r_mask; n_rla = r_rla; n_cnta = r_cnta; n_rlb = r_rlb; n_cntb = r_cntb;
        n_runa = r_runa; n_runb = r_runb; n_wa = r_wa; n_wb = r_wb;
        n_tod = r_tod; n_alm = r_alm; n_snap = r_snap;
        n_pre = r_pre; n_halt = r_halt; n_held = r_held; n_spend = r_spend;
        n_sact = r_sact; n_bits = r_bits; n_spin = r_spin; n_cntin = r_cntin;
        n_flagin = r_flagin; n_spout = r_spout; n_cntout = r_cntout;
        n_left = r_left; n_rd = r_rd;
        ua = 1'b0; tb = 1'b0; ub = 1'b0; rising = 1'b0; chg = 1'b0;
        alarm_chk = 1'b0; c0 = 1'b0; c1 = 1'b0; c2 = 1'b0;
        s0 = '0; s1 = '0; s2 = '0; v = i_write_data; hr = '0; pm = '0;
        cc = CW'(i_clock_count);

        if (i_ctl.load) begin
            n_rd = 8'h00;
            unique case (dtts_pkg::t_cmd'(i_cmd))
                dtts_pkg::CMD_WRITE: begin
                    unique case (i_reg_addr)
                        dtts_pkg::REG_PRA:  n_pra = v;
                        dtts_pkg::REG_PRB:  n_prb = v;
                        dtts_pkg::REG_DDRA: n_ddra = v;
                        dtts_pkg::REG_DDRB: n_ddrb = v;
                        dtts_pkg::REG_TALO: n_rla = {r_rla[15:8], v};
                        dtts_pkg::REG_TAHI: begin
                            n_rla = {v, r_rla[7:0]};
                            if (!r_runa) n_cnta = {v, r_rla[7:0]};
                        end
                        dtts_pkg::REG_TBLO: n_rlb = {r_rlb[15:8], v};
                        dtts_pkg::REG_TBHI: begin
                            n_rlb = {v, r_rlb[7:0]};
                            if (!r_runb) n_cntb = {v, r_rlb[7:0]};
                        end
                        dtts_pkg::REG_TOD0, dtts_pkg::REG_TOD1,
                        dtts_pkg::REG_TOD2, dtts_pkg::REG_TOD3: begin
                            if (i_reg_addr[1:0] == 2'd0) v = v & 8'h0F;
                            else if (i_reg_addr[1:0] == 2'd3) begin
                                v = v & 8'h9F;
                                if (!r_crb[7] && v[4:0] == 5'h12) v = v ^ 8'h80;
                            end else v = v & 8'h7F;
                            if (r_crb[7]) n_alm[i_reg_addr[1:0]] = v;
                            else begin
                                if (i_reg_addr[1:0] == 2'd3) n_halt = 1'b1;
                                n_tod[i_reg_addr[1:0]] = v;
                                if (i_reg_addr[1:0] == 2'd0) begin
                                    n_pre = 3'd0;
                                    n_halt = 1'b0;
                                end
                            end
                            alarm_chk = 1'b1;
                        end
                        dtts_pkg::REG_SDR: begin
                            n_sdr = v;
                            if (r_cra[6]) n_spend = 1'b1;
                        end
                        dtts_pkg::REG_ICR: begin
                            if (v[7]) n_mask = r_mask | v[6:0];
                            else n_mask = r_mask & ~v[6:0];
                        end
                        dtts_pkg::REG_CRA: begin
                            chg = r_cra[6] ^ v[6];
                            n_cra = v & 8'hEF;
                            if (v[4]) n_cnta = r_rla;
                            n_runa = v[0];
                            if (chg) begin
                                n_sact = 1'b0; n_spend = 1'b0; n_bits = 4'd0;
                                n_sr = 8'h00; n_spout = 1'b1; n_cntout = 1'b1;
                            end
                        end
                        default: begin
                            n_crb = v & 8'hEF;
                            if (v[4]) n_cntb = r_rlb;
                            n_runb = v[0];
                        end
                    endcase
                end
                dtts_pkg::CMD_READ: begin
                    unique case (i_reg_addr)
                        dtts_pkg::REG_PRA:  n_rd = r_pra;
                        dtts_pkg::REG_PRB:  n_rd = r_prb;
                        dtts_pkg::REG_DDRA: n_rd = r_ddra;
                        dtts_pkg::REG_DDRB: n_rd = r_ddrb;
                        dtts_pkg::REG_TALO: n_rd = r_cnta[7:0];
                        dtts_pkg::REG_TAHI: n_rd = r_cnta[15:8];
                        dtts_pkg::REG_TBLO: n_rd = r_cntb[7:0];
                        dtts_pkg::REG_TBHI: n_rd = r_cntb[15:8];
                        dtts_pkg::REG_TOD0, dtts_pkg::REG_TOD1,
                        dtts_pkg::REG_TOD2, dtts_pkg::REG_TOD3: begin
                            if (i_reg_addr[1:0] == 2'd3 && !r_held) begin
                                n_snap = r_tod;
                                n_held = 1'b1;
                                n_rd = r_tod[3];
                            end else if (r_held) n_rd = r_snap[i_reg_addr[1:0]];
                            else n_rd = r_tod[i_reg_addr[1:0]];
                            if (i_reg_addr[1:0] == 2'd0) n_held = 1'b0;
                        end
                        dtts_pkg::REG_SDR: n_rd = r_sdr;
                        dtts_pkg::REG_ICR: begin
                            n_rd = r_flags;
                            n_flags = 8'h00; n_wa = 1'b0; n_wb = 1'b0;
                        end
                        dtts_pkg::REG_CRA: n_rd = r_cra;
                        default: n_rd = r_crb;
                    endcase
                end
                dtts_pkg::CMD_TICK: begin
                    n_wa = 1'b0; n_wb = 1'b0;
                    n_left = (cc > MAXC) ? MAXC : cc;
                end
                dtts_pkg::CMD_TOD: begin
                    if (!r_halt) begin
                        n_pre = r_pre + 3'd1;
                        if (n_pre >= (r_cra[7] ? 3'd5 : 3'd6)) begin
                            n_pre = 3'd0;
                            s0 = bcd_step(r_tod[0], 8'h09);
                            n_tod[0] = s0[7:0];
                            c0 = s0[8];
                            if (c0) begin
                                s1 = bcd_step(r_tod[1], 8'h59);
                                n_tod[1] = s1[7:0];
                                c1 = s1[8];
                            end
                            if (c1) begin
                                s2 = bcd_step(r_tod[2], 8'h59);
                                n_tod[2] = s2[7:0];
                                c2 = s2[8];
                            end
                            if (c2) begin
                                pm = r_tod[3] & 8'h80;
                                hr = r_tod[3] & 8'h1F;
                                if (hr == 8'h11) begin
                                    hr = 8'h12; pm = pm ^ 8'h80;
                                end else if (hr == 8'h12 || hr == 8'h00) hr = 8'h01;
                                else if (hr == 8'h09) hr = 8'h10;
                                else hr = hr + 8'h01;
                                n_tod[3] = pm | hr;
                            end
                            alarm_chk = 1'b1;
                        end
                    end
                end
                dtts_pkg::CMD_SP: n_spin = i_pin_level;
                dtts_pkg::CMD_CNT: begin
                    rising = !r_cntin && i_pin_level;
                    n_cntin = i_pin_level;
                    if (rising) begin
                        if (r_cra[5] && r_runa) begin
                            if (r_cnta == 16'd1) begin
                                ua = 1'b1; n_cnta = r_rla;
                                if (r_cra[3]) begin
                                    n_runa = 1'b0; n_cra[0] = 1'b0;
                                end
                            end else n_cnta = r_cnta - 16'd1;
                        end
                        if (ua) begin
                            n_wa = 1'b1; n_flags[0] = 1'b1;
                        end
                        unique case (r_crb[6:5])
                            2'b01:   tb = 1'b1;
                            2'b10,
                            2'b11:   tb = ua;
                            default: tb = 1'b0;
                        endcase
                        if (tb && r_runb) begin
                            if (r_cntb == 16'd1) begin
                                n_cntb = r_rlb; n_wb = 1'b1; n_flags[1] = 1'b1;
                                if (r_crb[3]) begin
                                    n_runb = 1'b0; n_crb[0] = 1'b0;
                                end
                            end else n_cntb = r_cntb - 16'd1;
                        end
                        if (!r_cra[6]) begin
                            n_sr = {r_sr[6:0], r_spin};
                            n_bits = r_bits + 4'd1;
                            if (n_bits >= 4'd8) begin
                                n_sdr = n_sr; n_bits = 4'd0; n_sr = 8'h00;
                                n_flags[3] = 1'b1;
                            end
                        end
                    end
                end
                dtts_pkg::CMD_FLAG: begin
                    if (r_flagin && !i_pin_level) n_flags[4] = 1'b1;
                    n_flagin = i_pin_level;
                end
                default: ;
            endcase
            if (alarm_chk && n_tod[0] == n_alm[0] && n_tod[1] == n_alm[1] &&
                n_tod[2] == n_alm[2] && n_tod[3] == n_alm[3]) n_flags[2] = 1'b1;
        end

        // one system clock of a tick
        if (i_ctl.clk_en) begin
            n_left = r_left - CW'(1);
            if (!r_cra[5] && r_runa) begin
                if (r_cnta == 16'd1) begin
                    ua = 1'b1; n_cnta = r_rla;
                    if (r_cra[3]) begin
                        n_runa = 1'b0; n_cra[0] = 1'b0;
                    end
                end else n_cnta = r_cnta - 16'd1;
            end
            if (ua) begin
                n_wa = 1'b1; n_flags[0] = 1'b1;
                if (r_cra[6]) begin
                    if (!r_sact) begin
                        if (r_spend) begin
                            n_sr = r_sdr; n_bits = 4'd8; n_spend = 1'b0;
                            n_sact = 1'b1; n_cntout = 1'b0; n_spout = r_sdr[7];
                        end
                    end else begin
                        n_cntout = !r_cntout;
                        if (!n_cntout) n_spout = r_sr[7];
                        else begin
                            n_bits = r_bits - 4'd1;
                            n_sr = {r_sr[6:0], 1'b0};
                            if (n_bits == 4'd0) begin
                                n_sact = 1'b0; n_flags[3] = 1'b1;
                            end
                        end
                    end
                end
            end
            unique case (r_crb[6:5])
                2'b00:   ub = 1'b1;
                2'b10:   ub = ua;
                2'b11:   ub = r_cntin ? ua : 1'b0;
                default: ub = 1'b0;
            endcase
            if (ub && r_runb) begin
                if (r_cntb == 16'd1) begin
                    n_cntb = r_rlb; n_wb = 1'b1; n_flags[1] = 1'b1;
                    if (r_crb[3]) begin
                        n_runb = 1'b0; n_crb[0] = 1'b0;
                    end
                end else n_cntb = r_cntb - 16'd1;
            end
        end

        // interrupt line bit
        n_flags[7] = |(n_flags[6:0] & n_mask);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pra <= 8'hFF; r_prb <= 8'hFF; r_ddra <= '0; r_ddrb <= '0;
            r_flags <= '0; r_mask <= '0; r_cra <= '0; r_crb <= '0;
            r_rla <= '0; r_cnta <= '0; r_runa <= 1'b0;
            r_rlb <= '0; r_cntb <= '0; r_runb <= 1'b0;
            r_wa <= 1'b0; r_wb <= 1'b0;
            r_tod <= '{8'h00, 8'h00, 8'h00, 8'h01};
            r_alm <= '{default: 8'h00}; r_snap <= '{default: 8'h00};
            r_pre <= '0; r_halt <= 1'b1; r_held <= 1'b0;
            r_sdr <= '0; r_sr <= '0; r_bits <= '0; r_spend <= 1'b0; r_sact <= 1'b0;
            r_spin <= 1'b1; r_cntin <= 1'b1; r_flagin <= 1'b1;
            r_spout <= 1'b1; r_cntout <= 1'b1;
            r_left <= '0; r_rd <= '0;
        end else begin
            r_pra <= n_pra; r_prb <= n_prb; r_ddra <= n_ddra; r_ddrb <= n_ddrb;
            r_flags <= n_flags; r_mask <= n_mask; r_cra <= n_cra; r_crb <= n_crb;
            r_rla <= n_rla; r_cnta <= n_cnta; r_runa <= n_runa;
            r_rlb <= n_rlb; r_cntb <= n_cntb; r_runb <= n_runb;
            r_wa <= n_wa; r_wb <= n_wb;
            r_tod <= n_tod; r_alm <= n_alm; r_snap <= n_snap;
            r_pre <= n_pre; r_halt <= n_halt; r_held <= n_held;
            r_sdr <= n_sdr; r_sr <= n_sr; r_bits <= n_bits; r_spend <= n_spend;
            r_sact <= n_sact; r_spin <= n_spin; r_cntin <= n_cntin;
            r_flagin <= n_flagin; r_spout <= n_spout; r_cntout <= n_cntout;
            r_left <= n_left; r_rd <= n_rd;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            o_read_data       <= r_rd;
            o_irq_out         <= r_flags[7];
            o_sp_drive        <= r_spout;
            o_cnt_drive       <= r_cntout;
            o_timer_a_wrapped <= r_wa;
            o_timer_b_wrapped <= r_wb;
        end
    end

    assign o_sts.is_tick = (i_cmd == dtts_pkg::CMD_TICK);
    assign o_last = (r_left == CW'(0)) || (r_left == CW'(1));
    assign o_zero = (r_left == CW'(0));
endmodule

// ===== src/dtts_ctrl.sv =====
// sequencer: accepts an item, steps tick clocks, presents the result
// depends on dtts_pkg
module dtts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  dtts_pkg::t_sts i_sts,
    input  logic           i_last,
    input  logic           i_zero,
    output dtts_pkg::t_ctl o_ctl
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   take;

    // output slot frees when taken
    always_comb begin
        logic free;
        free = !r_ovalid || !i_stall;
        o_ctl = '0;
        n_state = r_state;
        n_ovalid = r_ovalid && i_stall;
        take = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                take = i_valid;
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state = i_sts.is_tick ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                if (i_zero) n_state = S_DONE;
                else begin
                    o_ctl.clk_en = 1'b1;
                    if (i_last) n_state = S_DONE;
                end
            end
            default: begin
                if (free) begin
                    o_ctl.finish = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    assign o_stall = !take;
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

// ===== src/dual_timer_tod_serial_io.sv =====
// Interface adapter with two down timers, BCD time-of-day clock and serial port.
// One input channel (i_valid / o_stall) carries a command item: bus write,
// bus read, clock tick, tod pulse or a pin level change. Every item gives
// exactly one result on the output channel (o_valid / i_stall).
// A non-tick item goes from the idle state to the done state; a tick item
// (its clock count saturated to MAX_CLOCKS_PER_TICK) passes through the run state
// first, the timer datapath advancing one system clock per cycle, and a
// tick with a zero count passes through it without stepping. The done state loads
// the result register. One item at a time: no new item is taken until the
// last one has left the done state.
// The result register holds the last result while the receiver stalls; the
// next item is taken in while that result waits, and its own result waits
// for the register to free.
// Reset (i_rst_n low, synchronous) returns all but the result register to power-up
// values: ports 0xFF, timers stopped at zero, tod halted at 1 o'clock, pins high.
// depends on dtts_pkg, dtts_ctrl, dtts_datapath
module dual_timer_tod_serial_io #(
    parameter int MAX_CLOCKS_PER_TICK = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_cmd,
    input  logic [3:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic [6:0] i_clock_count,
    input  logic       i_pin_level,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic       o_irq_out,
    output logic       o_sp_drive,
    output logic       o_cnt_drive,
    output logic       o_timer_a_wrapped,
    output logic       o_timer_b_wrapped
);
    dtts_pkg::t_ctl ctl;
    dtts_pkg::t_sts sts;
    logic           last;
    logic           zero_left;

    dtts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .i_last  (last),
        .i_zero  (zero_left),
        .o_ctl   (ctl)
    );

    // zero-clock tick skips stepping
    dtts_datapath #(.MAX_CLOCKS_PER_TICK(MAX_CLOCKS_PER_TICK)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .o_last            (last),
        .o_zero            (zero_left),
        .i_cmd             (i_cmd),
        .i_reg_addr        (i_reg_addr),
        .i_write_data      (i_write_data),
        .i_clock_count     (i_clock_count),
        .i_pin_level       (i_pin_level),
        .o_read_data       (o_read_data),
        .o_irq_out         (o_irq_out),
        .o_sp_drive        (o_sp_drive),
        .o_cnt_drive       (o_cnt_drive),
        .o_timer_a_wrapped (o_timer_a_wrapped),
        .o_timer_b_wrapped (o_timer_b_wrapped)
    );
endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the dual timer / tod / serial adapter
// depends on dtts_pkg and dual_timer_tod_serial_io
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_TICK = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [2:0] i_cmd = dtts_pkg::CMD_NONE;
    logic [3:0] i_reg_addr = '0;
    logic [7:0] i_write_data = '0;
    logic [6:0] i_clock_count = '0;
    logic       i_pin_level = 1'b1;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_read_data;
    logic       o_irq_out, o_sp_drive, o_cnt_drive;
    logic       o_timer_a_wrapped, o_timer_b_wrapped;

    dual_timer_tod_serial_io #(.MAX_CLOCKS_PER_TICK(MAX_TICK)) dut (.*);

    always #4 i_clk = ~i_clk;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
        logic       sp;
        logic       cnt;
        logic       wa;
        logic       wb;
    } t_status;

    t_status status_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_irq = 0;
    bit quiet = 0;
    int idle_pct = 24;

    // adapter state mirror
    logic [7:0]  m_pra, m_prb, m_ddra, m_ddrb, m_flags, m_cra, m_crb;
    logic [6:0]  m_mask;
    logic [15:0] m_lat_a, m_cnt_a, m_lat_b, m_cnt_b;
    logic        m_run_a, m_run_b, m_wa, m_wb;
    logic [7:0]  m_tod[4], m_alm[4], m_snap[4];
    logic [2:0]  m_presc;
    logic        m_halt, m_held;
    logic [7:0]  m_sdr, m_shift;
    logic [3:0]  m_bits;
    logic        m_pend, m_act, m_sp_in, m_cnt_in, m_flag_in, m_sp_out, m_cnt_out;

    function automatic void mirror_reset();
        m_pra = 8'hFF; m_prb = 8'hFF; m_ddra = 0; m_ddrb = 0;
        m_flags = 0; m_mask = 0; m_cra = 0; m_crb = 0;
        m_lat_a = 0; m_cnt_a = 0; m_run_a = 0; m_lat_b = 0; m_cnt_b = 0; m_run_b = 0;
        m_wa = 0; m_wb = 0;
        for (int i = 0; i < 4; i++) begin
            m_tod[i] = 0; m_alm[i] = 0; m_snap[i] = 0;
        end
        m_tod[3] = 8'h01;
        m_presc = 0; m_halt = 1; m_held = 0;
        m_sdr = 0; m_shift = 0; m_bits = 0; m_pend = 0; m_act = 0;
        m_sp_in = 1; m_cnt_in = 1; m_flag_in = 1; m_sp_out = 1; m_cnt_out = 1;
    endfunction

    function automatic void alarm_match();
        if (m_tod[0] == m_alm[0] && m_tod[1] == m_alm[1] &&
            m_tod[2] == m_alm[2] && m_tod[3] == m_alm[3]) m_flags |= 8'h04;
    endfunction

    function automatic bit bcd_inc(ref logic [7:0] v, input logic [7:0] limit);
        logic [4:0] lo;
        logic [8:0] hi;
        lo = {1'b0, v[3:0]} + 5'd1;
        hi = {1'b0, v[7:4], 4'h0};
        if (lo == 5'd10) begin
            lo = 0; hi = hi + 9'h10;
        end
        v = hi[7:0] | {3'b0, lo};
        if (v <= limit) return 0;
        v = 0;
        return 1;
    endfunction

    function automatic void tod_tenth();
        logic [7:0] pm, hr;
        if (bcd_inc(m_tod[0], 8'h09) && bcd_inc(m_tod[1], 8'h59) &&
            bcd_inc(m_tod[2], 8'h59)) begin
            pm = m_tod[3] & 8'h80;
            hr = m_tod[3] & 8'h1F;
            if (hr == 8'h11) begin
                hr = 8'h12; pm ^= 8'h80;
            end else if (hr == 8'h12 || hr == 8'h00) hr = 8'h01;
            else if (hr == 8'h09) hr = 8'h10;
            else hr = hr + 8'd1;
            m_tod[3] = pm | hr;
        end
        alarm_match();
    endfunction

    // one down-count step, returns underflow
    function automatic bit timer_step(ref logic [15:0] cnt, input logic [15:0] lat,
                                      ref logic run, ref logic [7:0] ctl);
        if (!run) return 0;
        if (cnt == 16'd1) begin
            cnt = lat;
            if (ctl[3]) begin
                run = 0; ctl[0] = 0;
            end
            return 1;
        end
        cnt = cnt - 16'd1;
        return 0;
    endfunction

    function automatic void shift_out_step();
        if (!m_act) begin
            if (!m_pend) return;
            m_shift = m_sdr; m_bits = 8; m_pend = 0; m_act = 1;
            m_cnt_out = 0; m_sp_out = m_shift[7];
            return;
        end
        m_cnt_out = ~m_cnt_out;
        if (!m_cnt_out) begin
            m_sp_out = m_shift[7];
            return;
        end
        m_bits = m_bits - 4'd1;
        m_shift = m_shift << 1;
        if (m_bits == 0) begin
            m_act = 0; m_flags |= 8'h08;
        end
    endfunction

    function automatic void bus_wr(logic [3:0] a, logic [7:0] v);
        bit chg, to_alarm;
        int i;
        case (a)
            dtts_pkg::REG_PRA:  m_pra = v;
            dtts_pkg::REG_PRB:  m_prb = v;
            dtts_pkg::REG_DDRA: m_ddra = v;
            dtts_pkg::REG_DDRB: m_ddrb = v;
            dtts_pkg::REG_TALO: m_lat_a[7:0] = v;
            dtts_pkg::REG_TAHI: begin
                m_lat_a[15:8] = v;
                if (!m_run_a) m_cnt_a = m_lat_a;
            end
            dtts_pkg::REG_TBLO: m_lat_b[7:0] = v;
            dtts_pkg::REG_TBHI: begin
                m_lat_b[15:8] = v;
                if (!m_run_b) m_cnt_b = m_lat_b;
            end
            dtts_pkg::REG_TOD0, dtts_pkg::REG_TOD1,
            dtts_pkg::REG_TOD2, dtts_pkg::REG_TOD3: begin
                i = a[1:0];
                to_alarm = m_crb[7];
                if (i == 0) v &= 8'h0F;
                else if (i == 3) begin
                    v &= 8'h9F;
                    if (!to_alarm && v[4:0] == 5'h12) v ^= 8'h80;
                end else v &= 8'h7F;
                if (to_alarm) m_alm[i] = v;
                else begin
                    if (i == 3) m_halt = 1;
                    m_tod[i] = v;
                    if (i == 0) begin
                        m_presc = 0; m_halt = 0;
                    end
                end
                alarm_match();
            end
            dtts_pkg::REG_SDR: begin
                m_sdr = v;
                if (m_cra[6]) m_pend = 1;
            end
            dtts_pkg::REG_ICR: begin
                if (v[7]) m_mask |= v[6:0];
                else m_mask &= ~v[6:0];
            end
            dtts_pkg::REG_CRA: begin
                chg = m_cra[6] ^ v[6];
                m_cra = v & 8'hEF;
                if (v[4]) m_cnt_a = m_lat_a;
                m_run_a = v[0];
                if (chg) begin
                    m_act = 0; m_pend = 0; m_bits = 0; m_shift = 0;
                    m_sp_out = 1; m_cnt_out = 1;
                end
            end
            default: begin
                m_crb = v & 8'hEF;
                if (v[4]) m_cnt_b = m_lat_b;
                m_run_b = v[0];
            end
        endcase
    endfunction

    function automatic logic [7:0] bus_rd(logic [3:0] a);
        logic [7:0] r;
        int i;
        case (a)
            dtts_pkg::REG_PRA:  r = m_pra;
            dtts_pkg::REG_PRB:  r = m_prb;
            dtts_pkg::REG_DDRA: r = m_ddra;
            dtts_pkg::REG_DDRB: r = m_ddrb;
            dtts_pkg::REG_TALO: r = m_cnt_a[7:0];
            dtts_pkg::REG_TAHI: r = m_cnt_a[15:8];
            dtts_pkg::REG_TBLO: r = m_cnt_b[7:0];
            dtts_pkg::REG_TBHI: r = m_cnt_b[15:8];
            dtts_pkg::REG_TOD0, dtts_pkg::REG_TOD1,
            dtts_pkg::REG_TOD2, dtts_pkg::REG_TOD3: begin
                i = a[1:0];
                if (i == 3 && !m_held) begin
                    for (int k = 0; k < 4; k++) m_snap[k] = m_tod[k];
                    m_held = 1;
                end
                r = m_held ? m_snap[i] : m_tod[i];
                if (i == 0) m_held = 0;
            end
            dtts_pkg::REG_SDR:  r = m_sdr;
            dtts_pkg::REG_ICR: begin
                r = m_flags; m_flags = 0; m_wa = 0; m_wb = 0;
            end
            dtts_pkg::REG_CRA:  r = m_cra;
            default:  r = m_crb;
        endcase
        return r;
    endfunction

    function automatic void run_clocks(int n);
        bit ua, tb;
        m_wa = 0; m_wb = 0;
        if (n > MAX_TICK) n = MAX_TICK;
        for (int k = 0; k < n; k++) begin
            ua = m_cra[5] ? 0 : timer_step(m_cnt_a, m_lat_a, m_run_a, m_cra);
            tb = 0;
            if (ua) begin
                m_wa = 1; m_flags |= 8'h01;
                if (m_cra[6]) shift_out_step();
            end
            case (m_crb[6:5])
                2'b00: tb = 1;
                2'b10: tb = ua;
                2'b11: tb = m_cnt_in ? ua : 0;
                default: tb = 0;
            endcase
            if (tb && timer_step(m_cnt_b, m_lat_b, m_run_b, m_crb)) begin
                m_wb = 1; m_flags |= 8'h02;
            end
        end
    endfunction

    function automatic void cnt_edge(logic lvl);
        bit rising, ua, tb;
        rising = !m_cnt_in && lvl;
        m_cnt_in = lvl;
        if (!rising) return;
        ua = m_cra[5] ? timer_step(m_cnt_a, m_lat_a, m_run_a, m_cra) : 0;
        if (ua) begin
            m_wa = 1; m_flags |= 8'h01;
        end
        case (m_crb[6:5])
            2'b01: tb = 1;
            2'b10, 2'b11: tb = ua;
            default: tb = 0;
        endcase
        if (tb && timer_step(m_cnt_b, m_lat_b, m_run_b, m_crb)) begin
            m_wb = 1; m_flags |= 8'h02;
        end
        if (!m_cra[6]) begin
            m_shift = {m_shift[6:0], m_sp_in};
            m_bits = m_bits + 4'd1;
            if (m_bits >= 8) begin
                m_sdr = m_shift; m_bits = 0; m_shift = 0; m_flags |= 8'h08;
            end
        end
    endfunction

    function automatic t_status predict_status(dtts_pkg::t_cmd c, logic [3:0] a,
                                               logic [7:0] d, logic [6:0] n, logic lvl);
        t_status s;
        logic [7:0] rd;
        rd = 0;
        case (c)
            dtts_pkg::CMD_WRITE: bus_wr(a, d);
            dtts_pkg::CMD_READ:  rd = bus_rd(a);
            dtts_pkg::CMD_TICK:  run_clocks(n);
            dtts_pkg::CMD_TOD: begin
                if (!m_halt) begin
                    m_presc = m_presc + 3'd1;
                    if (m_presc >= (m_cra[7] ? 3'd5 : 3'd6)) begin
                        m_presc = 0; tod_tenth();
                    end
                end
            end
            dtts_pkg::CMD_SP:    m_sp_in = lvl;
            dtts_pkg::CMD_CNT:   cnt_edge(lvl);
            dtts_pkg::CMD_FLAG: begin
                if (m_flag_in && !lvl) m_flags |= 8'h10;
                m_flag_in = lvl;
            end
            default: ;
        endcase
        if (m_flags[6:0] & m_mask) m_flags[7] = 1;
        else m_flags[7] = 0;
        s.rd = rd;
        s.irq = |(m_flags[6:0] & m_mask);
        s.sp = m_sp_out; s.cnt = m_cnt_out; s.wa = m_wa; s.wb = m_wb;
        return s;
    endfunction

    // send one item, predict at transfer
    task automatic send_item(dtts_pkg::t_cmd c, logic [3:0] a = 0, logic [7:0] d = 0,
                             logic [6:0] n = 0, logic lvl = 0);
        while (!quiet && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= c; i_reg_addr <= a; i_write_data <= d;
        i_clock_count <= n; i_pin_level <= lvl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        status_q.push_back(predict_status(c, a, d, n, lvl));
        n_sent++;
    endtask

    task automatic wr(logic [3:0] a, logic [7:0] d);
        send_item(dtts_pkg::CMD_WRITE, a, d);
    endtask

    task automatic rd(logic [3:0] a);
        send_item(dtts_pkg::CMD_READ, a);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (MAX_TICK + 8) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_status e;
        if (i_rst_n) i_stall <= (!quiet && $urandom_range(99) < idle_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (status_q.size() == 0) begin
                $display("%0t: result with nothing expected, rd=%h", $time, o_read_data);
                errors++;
            end else begin
                e = status_q.pop_front();
                n_checked++;
                if (o_irq_out) n_irq++;
                if (o_read_data !== e.rd) begin
                    $display("%0t: read_data exp %h got %h", $time, e.rd, o_read_data);
                    errors++;
                end
                if (o_irq_out !== e.irq) begin
                    $display("%0t: irq_out exp %b got %b", $time, e.irq, o_irq_out);
                    errors++;
                end
                if (o_sp_drive !== e.sp) begin
                    $display("%0t: sp_drive exp %b got %b", $time, e.sp, o_sp_drive);
                    errors++;
                end
                if (o_cnt_drive !== e.cnt) begin
                    $display("%0t: cnt_drive exp %b got %b", $time, e.cnt, o_cnt_drive);
                    errors++;
                end
                if (o_timer_a_wrapped !== e.wa) begin
                    $display("%0t: timer_a_wrapped exp %b got %b", $time, e.wa,
                             o_timer_a_wrapped);
                    errors++;
                end
                if (o_timer_b_wrapped !== e.wb) begin
                    $display("%0t: timer_b_wrapped exp %b got %b", $time, e.wb,
                             o_timer_b_wrapped);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int stuck = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", status_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_registers();
        for (int a = 0; a < 4; a++) begin
            wr(4'(a), 8'h00); rd(4'(a)); wr(4'(a), 8'hFF); rd(4'(a));
        end
        rd(dtts_pkg::REG_ICR);
        send_item(dtts_pkg::CMD_NONE, 4'hF, 8'hFF, 7'h7F, 1'b1);
    endtask

    task automatic test_timers();
        wr(dtts_pkg::REG_ICR, 8'h83);
        wr(dtts_pkg::REG_TALO, 8'h05); wr(dtts_pkg::REG_TAHI, 8'h00);
        wr(dtts_pkg::REG_TBLO, 8'h03); wr(dtts_pkg::REG_TBHI, 8'h00);
        wr(dtts_pkg::REG_CRB, 8'h51);                   // b counts a underflows
        wr(dtts_pkg::REG_CRA, 8'h19);                   // one-shot, force load
        send_item(dtts_pkg::CMD_TICK, 0, 0, 7'd4);
        send_item(dtts_pkg::CMD_TICK, 0, 0, 7'd0);      // zero tick
        send_item(dtts_pkg::CMD_TICK, 0, 0, 7'h7F);     // oversized tick
        rd(dtts_pkg::REG_TALO); rd(dtts_pkg::REG_CRA); rd(dtts_pkg::REG_ICR);
        // zero latch, full period
        wr(dtts_pkg::REG_TALO, 8'h00); wr(dtts_pkg::REG_TAHI, 8'h00);
        wr(dtts_pkg::REG_CRA, 8'h11);
        send_item(dtts_pkg::CMD_TICK, 0, 0, 7'd64);
        rd(dtts_pkg::REG_TAHI); rd(dtts_pkg::REG_TALO);
    endtask

    task automatic test_tod();
        wr(dtts_pkg::REG_CRB, 8'h80);
        wr(dtts_pkg::REG_TOD3, 8'h92); wr(dtts_pkg::REG_TOD2, 8'h00);
        wr(dtts_pkg::REG_TOD1, 8'h00);
        wr(dtts_pkg::REG_TOD0, 8'h01);
        wr(dtts_pkg::REG_CRB, 8'h00);
        wr(dtts_pkg::REG_ICR, 8'h84);
        wr(dtts_pkg::REG_TOD3, 8'h11); wr(dtts_pkg::REG_TOD2, 8'h59);
        wr(dtts_pkg::REG_TOD1, 8'h59);
        wr(dtts_pkg::REG_TOD0, 8'h09);
        repeat (6) send_item(dtts_pkg::CMD_TOD);
        rd(dtts_pkg::REG_TOD3); rd(dtts_pkg::REG_TOD2);
        rd(dtts_pkg::REG_TOD1); rd(dtts_pkg::REG_TOD0);
        wr(dtts_pkg::REG_TOD3, 8'h12);                  // hour twelve flips pm
        // non-bcd digits
        wr(dtts_pkg::REG_TOD2, 8'h7F); wr(dtts_pkg::REG_TOD0, 8'h0F);
        wr(dtts_pkg::REG_CRA, 8'h80);
        repeat (12) send_item(dtts_pkg::CMD_TOD);
        rd(dtts_pkg::REG_TOD3); rd(dtts_pkg::REG_TOD0); rd(dtts_pkg::REG_ICR);
        wr(dtts_pkg::REG_CRA, 8'h00);
    endtask

    task automatic test_serial();
        wr(dtts_pkg::REG_ICR, 8'h98);
        for (int i = 0; i < 8; i++) begin
            send_item(dtts_pkg::CMD_SP, 0, 0, 0, i[0]);
            send_item(dtts_pkg::CMD_CNT, 0, 0, 0, 0);
            send_item(dtts_pkg::CMD_CNT, 0, 0, 0, 1);
        end
        rd(dtts_pkg::REG_SDR); rd(dtts_pkg::REG_ICR);
        send_item(dtts_pkg::CMD_FLAG, 0, 0, 0, 0);
        send_item(dtts_pkg::CMD_FLAG, 0, 0, 0, 1);
        wr(dtts_pkg::REG_TALO, 8'h02); wr(dtts_pkg::REG_TAHI, 8'h00);
        wr(dtts_pkg::REG_CRA, 8'h51);                   // output mode, continuous
        wr(dtts_pkg::REG_SDR, 8'hA5);
        repeat (3) send_item(dtts_pkg::CMD_TICK, 0, 0, 7'd20);
        wr(dtts_pkg::REG_CRA, 8'h11);                   // mode change aborts
        rd(dtts_pkg::REG_ICR);
    endtask

    task automatic test_random(int count);
        int k, a;
        logic [7:0] d;
        for (int i = 0; i < count; i++) begin
            quiet = (i > count / 2 && i < count / 2 + 120);
            k = $urandom_range(99);
            d = 8'($urandom);
            a = $urandom_range(15);
            // keep tod writes mostly well-formed so the clock actually runs
            if (k < 25) begin
                if (a == dtts_pkg::REG_CRA || a == dtts_pkg::REG_CRB)
                    d = (d & 8'hF7) | ($urandom_range(3) == 0 ? 8'h08 : 8'h00);
                if (a >= dtts_pkg::REG_TOD0 && a <= dtts_pkg::REG_TOD3 &&
                    $urandom_range(3) != 0)
                    d = d & 8'h19;
                wr(4'(a), d);
            end else if (k < 45) rd(4'(a));
            else if (k < 65)
                send_item(dtts_pkg::CMD_TICK, 0, 0, 7'($urandom_range(127)));
            else if (k < 75) send_item(dtts_pkg::CMD_TOD);
            else if (k < 82) send_item(dtts_pkg::CMD_SP, 0, 0, 0, 1'($urandom));
            else if (k < 93) send_item(dtts_pkg::CMD_CNT, 0, 0, 0, 1'($urandom));
            else if (k < 98) send_item(dtts_pkg::CMD_FLAG, 0, 0, 0, 1'($urandom));
            else send_item(dtts_pkg::CMD_NONE, 4'(a), d, 7'($urandom), 1'($urandom));
        end
        quiet = 0;
    endtask

    initial begin
        mirror_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_registers();
        test_timers();
        test_tod();
        test_serial();
        drain();
        test_random(590);
        drain();
        $display("sent %0d items, checked %0d results, %0d with irq high",
                 n_sent, n_checked, n_irq);
        $display("covered bus map, timers, tod clock and alarm, serial in/out, pins");
        if (errors == 0 && status_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
